### design/lzwd_pkg.sv
// Shared types and constants for the LZW decoder.
package lzwd_pkg;

  localparam int CODE_W     = 9;
  localparam int NF_W       = CODE_W + 1;
  localparam int ROW_BYTES  = 8;
  localparam int ROWS       = 32;
  localparam int FIRST_FREE = 257;

  typedef enum logic [1:0] {
    CMD_BAD,
    CMD_KWK,
    CMD_KNOWN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prev;
    logic              add_en;
    logic [7:0]        add_idx;
  } cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] parent;
    logic [7:0]        chr;
    logic [8:0]        len;
  } dict_entry_t;

endpackage

### design/lzwd_front.sv
// Front end: accepts codes, tracks next free code and previous code, classifies.
module lzwd_front import lzwd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CODE_W-1:0] code_in,
  input  logic              in_valid,
  output logic              in_ready,
  output cmd_t              push_cmd,
  output logic              push,
  input  logic              q_full
);

  logic [NF_W-1:0]   next_free;
  logic [CODE_W-1:0] prior_code;
  logic              take;
  logic              is_reset;
  logic              is_bad;
  logic              is_kwk;
  logic              room;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign room     = !next_free[NF_W-1];
  assign is_reset = (code_in == '0);
  assign is_bad   = ({1'b0, code_in} > next_free) ||
                    (({1'b0, code_in} == next_free) && (prior_code == '0));
  assign is_kwk   = ({1'b0, code_in} == next_free);

  always_comb begin
    push_cmd.code    = code_in;
    push_cmd.prev    = prior_code;
    push_cmd.add_idx = next_free[7:0];
    priority if (is_bad) begin
      push_cmd.kind   = CMD_BAD;
      push_cmd.add_en = 1'b0;
    end else if (is_kwk) begin
      push_cmd.kind   = CMD_KWK;
      push_cmd.add_en = room;
    end else begin
      push_cmd.kind   = CMD_KNOWN;
      push_cmd.add_en = room && (prior_code != '0);
    end
  end

  assign push = take && !is_reset;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free  <= NF_W'(FIRST_FREE);
      prior_code <= '0;
    end else if (take) begin
      if (is_reset) begin
        next_free  <= NF_W'(FIRST_FREE);
        prior_code <= '0;
      end else if (!is_bad) begin
        prior_code <= code_in;
        if (push_cmd.add_en) next_free <= next_free + NF_W'(1);
      end
    end
  end

endmodule

### design/lzwd_queue.sv
// Two-entry command queue between front and back.
module lzwd_queue import lzwd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push,
  output logic full,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

### design/lzwd_back.sv
// Back end: dictionary walk, string buffer and packing of output words.
module lzwd_back import lzwd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        pop_cmd,
  input  logic        pop_valid,
  output logic        pop,
  output logic [63:0] bytes_out,
  output logic [3:0]  byte_count,
  output logic        last_chunk,
  output logic        bad_code,
  output logic        out_valid,
  input  logic        out_ready
);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_ADD, S_ERD, S_EOUT, S_BAD
  } state_t;

  state_t            state;
  logic [CODE_W-1:0] cur;
  logic [7:0]        pos;
  logic              first_step;
  logic [8:0]        new_len;
  logic [8:0]        slen;
  logic [7:0]        first_b;
  logic [CODE_W-1:0] add_prev;
  logic              add_en;
  logic [7:0]        add_idx;
  logic [4:0]        row;

  dict_entry_t dict_mem [256];
  dict_entry_t d_rdata;
  dict_entry_t d_wdata;
  logic [7:0]  d_raddr;
  logic [7:0]  d_waddr;
  logic        d_we;

  logic [63:0] sbuf [ROWS];
  logic [63:0] s_rdata;
  logic [7:0]  s_wpos;
  logic [7:0]  s_wbyte;
  logic        s_we;

  logic        walk_root;
  logic [7:0]  walk_byte;
  logic [7:0]  walk_pos;
  logic [8:0]  len_m1;
  logic [8:0]  walk_len;
  logic        start_kwk;
  logic        slot_free;
  logic        emit;
  logic [8:0]  rem;
  logic [3:0]  cnt;
  logic        is_last;
  logic [63:0] row_masked;

  assign walk_root = !(cur[8] && (cur[7:0] != 8'd0));
  assign len_m1    = d_rdata.len - 9'd1;
  assign walk_byte = walk_root ? (cur[7:0] - 8'd1) : d_rdata.chr;
  assign walk_pos  = first_step ? (walk_root ? 8'd0 : len_m1[7:0]) : pos;
  assign walk_len  = walk_root ? 9'd1 : d_rdata.len;

  assign pop         = (state == S_IDLE) && pop_valid;
  assign start_kwk   = pop && (pop_cmd.kind == CMD_KWK);
  assign slot_free   = !out_valid || out_ready;
  assign emit        = slot_free && ((state == S_EOUT) || (state == S_BAD));

  // Dictionary port: read for the walk, write for new entries.
  always_comb begin
    d_raddr = (state == S_WALK) ? d_rdata.parent[7:0] : pop_cmd.code[7:0];
    d_wdata.chr = first_b;
    d_wdata.len = slen + 9'd1;
    if (state == S_ADD) begin
      d_we           = add_en;
      d_waddr        = add_idx;
      d_wdata.parent = add_prev;
    end else begin
      d_we           = start_kwk && pop_cmd.add_en;
      d_waddr        = pop_cmd.add_idx;
      d_wdata.parent = pop_cmd.prev;
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) dict_mem[d_waddr] <= d_wdata;
    d_rdata <= dict_mem[d_raddr];
  end

  // String buffer: one byte lane written, one row read per cycle.
  always_comb begin
    if (state == S_WALK) begin
      s_we    = 1'b1;
      s_wpos  = walk_pos;
      s_wbyte = walk_byte;
    end else begin
      s_we    = start_kwk && !slen[8];
      s_wpos  = slen[7:0];
      s_wbyte = first_b;
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) sbuf[s_wpos[7:3]][{s_wpos[2:0], 3'b000} +: 8] <= s_wbyte;
    s_rdata <= sbuf[row];
  end

  assign rem     = slen - {1'b0, row, 3'b000};
  assign cnt     = (rem > 9'd8) ? 4'd8 : rem[3:0];
  assign is_last = (rem <= 9'd8) || (row == 5'(ROWS - 1));

  always_comb begin
    for (int i = 0; i < ROW_BYTES; i++) begin
      row_masked[i*8 +: 8] = (4'(i) < cnt) ? s_rdata[i*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      slen       <= 9'd0;
      first_step <= 1'b0;
      row        <= 5'd0;
      add_en     <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            add_prev <= pop_cmd.prev;
            add_en   <= pop_cmd.add_en;
            add_idx  <= pop_cmd.add_idx;
            row      <= 5'd0;
            unique case (pop_cmd.kind)
              CMD_BAD: state <= S_BAD;
              CMD_KWK: begin
                if (!slen[8]) slen <= slen + 9'd1;
                state <= S_ERD;
              end
              CMD_KNOWN: begin
                cur        <= pop_cmd.code;
                first_step <= 1'b1;
                state      <= S_WALK;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_WALK: begin
          first_step <= 1'b0;
          if (first_step) new_len <= walk_len;
          pos <= walk_pos - 8'd1;
          if (walk_root) begin
            first_b <= walk_byte;
            state   <= S_ADD;
          end else begin
            cur <= d_rdata.parent;
          end
        end
        S_ADD: begin
          slen  <= new_len;
          state <= S_ERD;
        end
        S_ERD: state <= S_EOUT;
        S_EOUT: begin
          if (slot_free) begin
            bytes_out  <= row_masked;
            byte_count <= cnt;
            last_chunk <= is_last;
            bad_code   <= 1'b0;
            row        <= row + 5'd1;
            state      <= is_last ? S_IDLE : S_ERD;
          end
        end
        S_BAD: begin
          if (slot_free) begin
            bytes_out  <= 64'd0;
            byte_count <= 4'd0;
            last_chunk <= 1'b1;
            bad_code   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count <= 4'd8)
    else $error("byte_count above eight");
  a_bad_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_code) |-> (byte_count == 4'd0 && last_chunk))
    else $error("bad word carries data");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EOUT) |-> (slen != 9'd0))
    else $error("emitting empty string");
`endif

endmodule

### design/lzw_decoder.sv
// LZW decoder, fixed 9-bit codes: one code in, up to 32 words of 8 bytes out.
// A known code walks the dictionary from its last byte to its root (S_WALK), then S_ADD,
// then S_ERD and S_EOUT for each word; the back end takes the next code only when it is done.
// The walk reads one dictionary entry per cycle from the dictionary RAM.
// A bad code gives one bad word; a reset code (0) is absorbed by the front.
// Reset: synchronous rst clears control state; root codes come from logic, no clearing pass.
module lzw_decoder import lzwd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CODE_W-1:0] code_in,
  input  logic              in_valid,
  output logic              in_ready,
  output logic [63:0]       bytes_out,
  output logic [3:0]        byte_count,
  output logic              last_chunk,
  output logic              bad_code,
  output logic              out_valid,
  input  logic              out_ready
);

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic q_full;
  logic pop_valid;
  logic pop;

  lzwd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .code_in  (code_in),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .push_cmd (push_cmd),
    .push     (push),
    .q_full   (q_full)
  );

  lzwd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_cmd  (push_cmd),
    .push      (push),
    .full      (q_full),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop       (pop)
  );

  lzwd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .bytes_out  (bytes_out),
    .byte_count (byte_count),
    .last_chunk (last_chunk),
    .bad_code   (bad_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

### sim/tb_top.sv
// Testbench for the LZW decoder: random and directed code streams checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import lzwd_pkg::*;

  localparam int DICT_N    = 1 << CODE_W;
  localparam int STR_N     = DICT_N - 256;
  localparam int MAX_WORDS = 32;
  localparam int LIMIT     = 2000000;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic        bad;
  } word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [CODE_W-1:0] code_in = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [63:0]       bytes_out;
  logic [3:0]        byte_count;
  logic              last_chunk;
  logic              bad_code;
  logic              out_valid;
  logic              out_ready = 1'b0;

  lzw_decoder u_top (
    .clk(clk), .rst(rst), .code_in(code_in), .in_valid(in_valid), .in_ready(in_ready),
    .bytes_out(bytes_out), .byte_count(byte_count), .last_chunk(last_chunk),
    .bad_code(bad_code), .out_valid(out_valid), .out_ready(out_ready)
  );

  // predictor state
  logic [CODE_W-1:0] dict_parent [DICT_N];
  logic [7:0]        dict_byte [DICT_N];
  int unsigned       free_code;
  int unsigned       last_code;
  logic [7:0]        cur_str [STR_N];
  int unsigned       cur_len;

  logic [CODE_W-1:0] code_q [$];
  word_t             expected_words [$];
  int                errors = 0;
  int                cycles = 0;
  bit                quiet_phase = 1'b0;
  bit                stim_done = 1'b0;

  // generator-side shadow of next free code and previous code
  int unsigned       gen_free;
  int unsigned       gen_prev;

  function automatic void dict_reset();
    for (int k = 0; k < DICT_N; k++) begin
      dict_parent[k] = '0;
      dict_byte[k]   = (k >= 1 && k <= 256) ? 8'(k - 1) : 8'h00;
    end
    free_code = FIRST_FREE;
    last_code = 0;
    cur_len   = 0;
  endfunction

  function automatic void dict_add(int unsigned par, logic [7:0] b);
    if (free_code < DICT_N) begin
      dict_parent[free_code] = CODE_W'(par);
      dict_byte[free_code]   = b;
      free_code++;
    end
  endfunction

  function automatic void decode_code(logic [CODE_W-1:0] c);
    int unsigned code, pos, cnt, cur, len;
    logic [7:0]  rev [STR_N];
    logic [7:0]  first;
    word_t       w;
    code = 32'(c);
    if (code == 0) begin
      dict_reset();
      return;
    end
    if (code > free_code || (code == free_code && last_code == 0)) begin
      w = '{bytes: '0, count: '0, last: 1'b1, bad: 1'b1};
      expected_words.push_back(w);
      return;
    end
    if (code == free_code) begin
      first = cur_str[0];
      dict_add(last_code, first);
      if (cur_len < STR_N) begin
        cur_str[cur_len] = first;
        cur_len++;
      end
    end else begin
      len = 0;
      cur = code;
      while (cur != 0 && len < STR_N) begin
        rev[len] = dict_byte[cur];
        cur = 32'(dict_parent[cur]);
        len++;
      end
      for (int i = 0; i < len; i++) cur_str[i] = rev[len - 1 - i];
      cur_len = len;
      if (last_code != 0 && len > 0) dict_add(last_code, cur_str[0]);
    end
    last_code = code;
    pos = 0;
    for (int n = 0; n < MAX_WORDS; n++) begin
      cnt = cur_len - pos;
      if (cnt > ROW_BYTES) cnt = ROW_BYTES;
      w = '0;
      for (int i = 0; i < cnt; i++) w.bytes[8*i +: 8] = cur_str[pos + i];
      pos += cnt;
      w.count = 4'(cnt);
      w.last  = (pos >= cur_len || n == MAX_WORDS - 1);
      expected_words.push_back(w);
      if (pos >= cur_len) break;
    end
  endfunction

  // generator tracks legality so most codes are valid
  function automatic void push_code(int unsigned c);
    code_q.push_back(CODE_W'(c));
    if (c == 0) begin
      gen_free = FIRST_FREE;
      gen_prev = 0;
    end else if (c > gen_free || (c == gen_free && gen_prev == 0)) begin
      // illegal: no state change
    end else begin
      if (gen_prev != 0 && gen_free < DICT_N) gen_free++;
      gen_prev = c;
    end
  endfunction

  function automatic int unsigned legal_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10 && gen_prev != 0) return gen_free;            // KwKwK
    if (r < 50 && gen_free > FIRST_FREE) return $urandom_range(FIRST_FREE, gen_free - 1);
    return $urandom_range(1, 256);
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    gen_free = FIRST_FREE;
    gen_prev = 0;
    // directed: bad first, roots at extremes, KwKwK, reset, above next free
    push_code(FIRST_FREE);
    push_code(511);
    push_code(1);
    push_code(256);
    push_code(FIRST_FREE + 1);
    push_code(FIRST_FREE + 2);
    push_code(FIRST_FREE + 2);
    push_code(FIRST_FREE);
    push_code(0);
    push_code(0);
    push_code(170);
    push_code(FIRST_FREE);
    push_code(FIRST_FREE + 1);
    push_code(FIRST_FREE + 2);
    push_code(FIRST_FREE + 3);
    push_code(85);
    push_code(FIRST_FREE + 200);
    // random: well-formed runs, noise, occasional reset; one run fills the dictionary
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(0, 99) < 3) push_code(0);
      else if ($urandom_range(0, 99) < 6) push_code($urandom_range(0, DICT_N - 1));
      else push_code(legal_code());
    end
    push_code(0);
    push_code($urandom_range(1, 256));
    while (gen_free < DICT_N) push_code(($urandom_range(0, 1) != 0) ? gen_free : gen_free - 1);
    for (int i = 0; i < 10; i++) push_code(legal_code());
    push_code(511);
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) decode_code(code_in);
      if (code_q.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 35)) begin
        code_in  <= code_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (code_q.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: bytes %h count %0d", bytes_out, byte_count);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (bytes_out !== w.bytes) begin
            $error("bytes_out exp %h got %h", w.bytes, bytes_out); errors++;
          end
          if (byte_count !== w.count) begin
            $error("byte_count exp %0d got %0d", w.count, byte_count); errors++;
          end
          if (last_chunk !== w.last) begin
            $error("last_chunk exp %0b got %0b", w.last, last_chunk); errors++;
          end
          if (bad_code !== w.bad) begin
            $error("bad_code exp %0b got %0b", w.bad, bad_code); errors++;
          end
        end
      end
      out_ready <= quiet_phase || ($urandom_range(0, 99) >= 35);
    end
  end

  initial begin
    dict_reset();
    for (int k = 0; k < STR_N; k++) cur_str[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // hold a stretch with no idling on either side
    repeat (3000) @(posedge clk);
    quiet_phase <= 1'b1;
    repeat (3000) @(posedge clk);
    quiet_phase <= 1'b0;
  end

  // cycle limit and end of run
  initial begin
    int drain;
    drain = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("** lzw_decoder: FAILED **");
        $finish;
      end
      if (stim_done && !in_valid && expected_words.size() == 0) drain++;
      else drain = 0;
      if (drain > 400) begin
        if (errors == 0) $display("** lzw_decoder: PASSED **");
        else $display("** lzw_decoder: FAILED **");
        $finish;
      end
    end
  end

endmodule
